@@ design/arpc_pkg.sv @@
package arpc_pkg;

  localparam int unsigned EntriesDef = 16;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_LOOKUP = 1'b1
  } arpc_func_e;

  typedef enum logic {
    STATUS_OK        = 1'b0,
    STATUS_NOT_FOUND = 1'b1
  } arpc_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } arpc_state_e;

  typedef struct packed {
    arpc_func_e  func;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } arpc_in_t;

  typedef struct packed {
    arpc_status_e status;
    logic [47:0]  mac_result;
  } arpc_out_t;

  typedef struct packed {
    logic        active;
    arpc_func_e  func;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        hit;
    logic [47:0] hit_mac;
    logic        free_found;
  } arpc_carry_t;

  typedef struct packed {
    logic        en;
    logic        set_key;
    logic [31:0] ip;
    logic [47:0] mac;
  } arpc_wr_t;

endpackage

@@ design/arpc_cell.sv @@
module arpc_cell #(
  parameter int unsigned ENTRIES = arpc_pkg::EntriesDef,
  parameter int unsigned INDEX   = 0,
  localparam int unsigned IdxW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  arpc_pkg::arpc_carry_t carry_i,
  input  logic [IdxW-1:0]       hit_idx_i,
  input  logic [IdxW-1:0]       free_idx_i,
  output arpc_pkg::arpc_carry_t carry_o,
  output logic [IdxW-1:0]       hit_idx_o,
  output logic [IdxW-1:0]       free_idx_o,
  input  arpc_pkg::arpc_wr_t    wr_i,
  input  logic [IdxW-1:0]       wr_idx_i
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(INDEX);

  logic                  valid_q;
  logic [31:0]           ip_q;
  logic [47:0]           mac_q;
  arpc_pkg::arpc_carry_t carry_d, carry_q;
  logic [IdxW-1:0]       hit_idx_d, hit_idx_q;
  logic [IdxW-1:0]       free_idx_d, free_idx_q;
  logic                  wr_sel;

  assign wr_sel = wr_i.en && (wr_idx_i == MyIdx);

  always_comb begin
    carry_d    = carry_i;
    hit_idx_d  = hit_idx_i;
    free_idx_d = free_idx_i;
    if (carry_i.active && valid_q && (ip_q == carry_i.ip) && !carry_i.hit) begin
      carry_d.hit     = 1'b1;
      carry_d.hit_mac = mac_q;
      hit_idx_d       = MyIdx;
    end
    if (carry_i.active && !valid_q && !carry_i.free_found) begin
      carry_d.free_found = 1'b1;
      free_idx_d         = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
      if (wr_sel && wr_i.set_key) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (wr_sel) begin
      mac_q <= wr_i.mac;
      if (wr_i.set_key) begin
        ip_q <= wr_i.ip;
      end
    end
  end

  assign carry_o    = carry_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;

endmodule

@@ design/arp_cache_table.sv @@
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid_i/in_stall_o | arpc_in_t: func, ip_addr, mac_addr
// out     | output    | out_valid_o/out_stall_i | arpc_out_t: status, mac_result
//
// Each entry lives in one cell, and a request word walks the row one cell per cycle.
// A new item is accepted only in the idle state, after the last item has finished its walk and its finish state.
// An insert writes its target cell in the cycle after the walk ends.
// Reset clears every valid mark at once, so the table is empty right after reset.
// A stalled result holds the next item at the end of its walk until the result is taken.
module arp_cache_table #(
  parameter int unsigned ENTRIES = arpc_pkg::EntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  arpc_pkg::arpc_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output arpc_pkg::arpc_out_t out_word_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  arpc_pkg::arpc_state_e state_d, state_q;
  arpc_pkg::arpc_carry_t inj_d, inj_q;
  arpc_pkg::arpc_carry_t res_d, res_q;
  logic [IdxW-1:0]       res_hidx_d, res_hidx_q;
  logic [IdxW-1:0]       res_fidx_d, res_fidx_q;
  logic                  out_valid_d, out_valid_q;
  arpc_pkg::arpc_out_t   out_d, out_q;
  arpc_pkg::arpc_wr_t    wr;
  logic [IdxW-1:0]       wr_idx;
  logic                  accept;

  arpc_pkg::arpc_carry_t carry [ENTRIES+1];
  logic [IdxW-1:0]       hidx  [ENTRIES+1];
  logic [IdxW-1:0]       fidx  [ENTRIES+1];

  assign carry[0] = inj_q;
  assign hidx[0]  = '0;
  assign fidx[0]  = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arpc_cell #(
      .ENTRIES(ENTRIES),
      .INDEX  (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .carry_i   (carry[g]),
      .hit_idx_i (hidx[g]),
      .free_idx_i(fidx[g]),
      .carry_o   (carry[g+1]),
      .hit_idx_o (hidx[g+1]),
      .free_idx_o(fidx[g+1]),
      .wr_i      (wr),
      .wr_idx_i  (wr_idx)
    );
  end

  assign in_stall_o = (state_q != arpc_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    inj_d       = inj_q;
    res_d       = res_q;
    res_hidx_d  = res_hidx_q;
    res_fidx_d  = res_fidx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr          = '0;
    wr.set_key  = !res_q.hit;
    wr.ip       = res_q.ip;
    wr.mac      = res_q.mac;
    if (res_q.hit) begin
      wr_idx = res_hidx_q;
    end else if (res_q.free_found) begin
      wr_idx = res_fidx_q;
    end else begin
      wr_idx = '0;
    end
    inj_d.active = 1'b0;

    case (state_q)
      arpc_pkg::ST_IDLE: begin
        if (accept) begin
          inj_d.active     = 1'b1;
          inj_d.func       = in_word_i.func;
          inj_d.ip         = in_word_i.ip_addr;
          inj_d.mac        = in_word_i.mac_addr;
          inj_d.hit        = 1'b0;
          inj_d.hit_mac    = '0;
          inj_d.free_found = 1'b0;
          state_d          = arpc_pkg::ST_SCAN;
        end
      end
      arpc_pkg::ST_SCAN: begin
        if (carry[ENTRIES].active) begin
          res_d      = carry[ENTRIES];
          res_hidx_d = hidx[ENTRIES];
          res_fidx_d = fidx[ENTRIES];
          state_d    = arpc_pkg::ST_FINISH;
        end
      end
      arpc_pkg::ST_FINISH: begin
        wr.en = (res_q.func == arpc_pkg::FUNC_INSERT);
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (res_q.func == arpc_pkg::FUNC_INSERT) begin
            out_d.status     = arpc_pkg::STATUS_OK;
            out_d.mac_result = '0;
          end else if (res_q.hit) begin
            out_d.status     = arpc_pkg::STATUS_OK;
            out_d.mac_result = res_q.hit_mac;
          end else begin
            out_d.status     = arpc_pkg::STATUS_NOT_FOUND;
            out_d.mac_result = '0;
          end
          state_d = arpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = arpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arpc_pkg::ST_IDLE;
      inj_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inj_q       <= inj_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    res_hidx_q <= res_hidx_d;
    res_fidx_q <= res_fidx_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
